FILE: hw/rtl/dsa_pkg.sv
// Package for the double-ended stack allocator: commands, status codes,
// default sizes and configuration register indices. No dependencies.
`default_nettype none
package dsa_pkg;
  localparam int unsigned PoolGranules     = 4096;
  localparam int unsigned StateDepth       = 16;
  localparam int unsigned StateRecordBytes = 32;

  localparam logic [2:0] CmdInit    = 3'd0;
  localparam logic [2:0] CmdAlloc   = 3'd1;
  localparam logic [2:0] CmdFree    = 3'd2;
  localparam logic [2:0] CmdRealloc = 3'd3;
  localparam logic [2:0] CmdPush    = 3'd4;
  localparam logic [2:0] CmdPop     = 3'd5;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoSpace  = 3'd1;
  localparam logic [2:0] StNotNewest = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StEmpty    = 3'd4;
  localparam logic [2:0] StBadInit  = 3'd5;

  localparam logic [0:0] CfgStart = 1'b0;
  localparam logic [0:0] CfgEnd   = 1'b1;
endpackage
`default_nettype wire

FILE: hw/rtl/double_ended_stack_allocator_unit.sv
// Top level of the double-ended stack allocator: command sequencer, head
// registers and the link and saved-state memories. Depends on dsa_pkg, dsa_ram.
//
// Each request is accepted, then evaluated. The accept cycle issues the read of
// the link memory and the saved-state memory. The next cycle evaluates the
// command on the registered read data, writes at most one link entry back and
// loads the result register. A command that also clears a second link entry
// (init, a left allocation, a push or a realloc that fits) does that write in
// the cycle after the evaluation, and the write holds off the next request
// while it is pending. A result waiting at the output blocks the next request
// until it is taken, and no new request is accepted while one is evaluated.
// Link memory holds PoolGranules+2 entries of headers and is not cleared; no
// clearing pass is needed after reset.
`default_nettype none
module double_ended_stack_allocator_unit #(
  parameter int unsigned PoolGranules     = dsa_pkg::PoolGranules,
  parameter int unsigned StateDepth       = dsa_pkg::StateDepth,
  parameter int unsigned StateRecordBytes = dsa_pkg::StateRecordBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[2:0], request_size[34:3], side[35], block_addr[67:36], zero fill [71:68]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_addr[31:0], status[34:32], free_bytes[51:35],
  // largest_available[68:52], zero fill [71:69]
  output logic      [71:0] m_axis_tdata
);
  localparam int unsigned LinkDepth = PoolGranules + 2;
  localparam int unsigned LinkW     = $clog2(LinkDepth);
  localparam int unsigned FreeW     = $clog2(PoolGranules * 16 + 1);
  localparam int unsigned SdW       = $clog2(StateDepth + 1);
  localparam int unsigned SaW       = (StateDepth > 1) ? $clog2(StateDepth) : 1;
  localparam int unsigned RecW      = FreeW + 64;
  localparam logic [32:0] MaxBytes  = 33'(PoolGranules * 16);
  localparam logic [32:0] RecSize   = 33'(((StateRecordBytes + 15) / 16) * 16 + 16);

  // configuration
  logic [31:0] start_q, end_q;
  // allocator state
  logic [FreeW-1:0] free_q;
  logic [31:0] left_q, right_q, base_q;
  logic [SdW-1:0] cnt_q;
  // request holding
  logic        busy_q;
  logic [2:0]  cmd_q;
  logic [31:0] req_q, baddr_q;
  logic        side_q;
  // output
  logic        ovld_q;
  logic [71:0] odata_q;

  // link memory and saved stack ports
  logic             lwe;
  logic [LinkW-1:0] lwa, lra;
  logic [LinkW-1:0] lwd, lrd;
  logic             swe;
  logic [SaW-1:0]   swa, sra;
  logic [RecW-1:0]  swd, srd;

  // link memory write uses the shared port
  logic             lwe_r;
  logic [LinkW-1:0] lwa_r, lwd_r;

  // second write pending
  logic             pend_q;
  logic [LinkW-1:0] pend_a_q;

  // helper: byte offset of a from origin b-16, valid if aligned and in range
  function automatic logic [32:0] gran(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] off;
    begin
      off = a - (b - 32'd16);
      gran = {(off[3:0] == 4'd0) && ((off >> 4) <= 32'(PoolGranules + 1)), off};
    end
  endfunction

  assign s_axis_tready = !busy_q && !pend_q && (!ovld_q || m_axis_tready);

  // Issue reads at accept time, link address from the incoming request
  logic [32:0] in_h;
  assign in_h = gran(s_axis_tdata[67:36] - 32'd16, base_q);
  assign lra  = LinkW'(in_h[31:4]);
  assign sra  = (cnt_q == '0) ? '0 : SaW'(cnt_q - SdW'(1));

  dsa_ram #(.Width(LinkW), .Depth(LinkDepth)) u_link (
    .clk_i, .we_i(lwe_r), .waddr_i(lwa_r), .wdata_i(lwd_r), .raddr_i(lra), .rdata_o(lrd)
  );
  dsa_ram #(.Width(RecW), .Depth(StateDepth)) u_saved (
    .clk_i, .we_i(busy_q && swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra),
    .rdata_o(srd)
  );

  // Evaluate command on registered read data
  logic [FreeW-1:0] free_d;
  logic [31:0] left_d, right_d, base_d, res;
  logic [SdW-1:0] cnt_d;
  logic [2:0] st;
  logic [32:0] sz, hg, lg, gnl, gol;
  logic [31:0] offh, offl, offr, h, nl;
  logic [33:0] fsum, ps, pe;
  logic [LinkW-1:0] lwa2;
  logic lwe2;
  logic [31:0] fl;
  logic [FreeW-1:0] ff;

  always_comb begin
    free_d = free_q; left_d = left_q; right_d = right_q; base_d = base_q;
    cnt_d = cnt_q; res = '0; st = dsa_pkg::StOk;
    lwe = 1'b0; lwa = '0; lwd = '0; lwe2 = 1'b0; lwa2 = '0;
    swe = 1'b0; swa = SaW'(cnt_q); swd = {free_q, left_q, right_q};
    sz = '0; fsum = '0;
    h = baddr_q - 32'd16;
    hg = gran(h, base_q);
    lg = gran(left_q, base_q);
    offh = {hg[31:4], 4'd0};
    offl = left_q - (base_q - 32'd16);
    offr = right_q - (base_q - 32'd16);
    nl = 32'(lrd);
    gnl = '0; gol = '0; fl = left_q; ff = free_q;
    ps = {2'b0, start_q} + 34'd15; ps = {ps[33:4], 4'd0} + 34'd16;
    pe = {2'b0, end_q[31:4], 4'd0} - 34'd16;
    case (cmd_q)
      dsa_pkg::CmdInit: begin
        if ($signed(pe) < $signed(ps) || (pe - ps) > 34'(MaxBytes)) begin
          st = dsa_pkg::StBadInit;
        end else begin
          base_d = ps[31:0]; left_d = ps[31:0] - 32'd16; right_d = pe[31:0];
          free_d = FreeW'(pe - ps); cnt_d = '0;
          lwe = 1'b1; lwa = '0;
          lwe2 = 1'b1; lwa2 = LinkW'(((pe - ps) >> 4) + 34'd1);
        end
      end
      dsa_pkg::CmdFree, dsa_pkg::CmdRealloc: begin
        // realloc check: newest left block
        if (cmd_q == dsa_pkg::CmdRealloc &&
            !(hg[32] && lg[32] && hg[31:4] < lg[31:4] && nl == {4'd0, lg[31:4]})) begin
          st = dsa_pkg::StNotNewest;
        end else if (hg[32]) begin
          if (offh < offl) begin
            fsum = 34'(free_q) + 34'(offl - offh);
            ff = (fsum > 34'(MaxBytes)) ? FreeW'(MaxBytes) : FreeW'(fsum);
            fl = h;
            free_d = ff; left_d = h;
            lwe = 1'b1; lwa = LinkW'(hg[31:4]);
          end else if (offh >= offr && nl > {4'd0, hg[31:4]}) begin
            fsum = 34'(free_q) + 34'({nl[27:0], 4'd0}) - 34'(offr);
            free_d = (fsum > 34'(MaxBytes)) ? FreeW'(MaxBytes) : FreeW'(fsum);
            right_d = base_q - 32'd16 + {nl[27:0], 4'd0};
          end
          if (cmd_q == dsa_pkg::CmdRealloc) begin
            // left alloc after free
            sz = {1'b0, req_q} + 33'd15; sz = {sz[32:4], 4'd0} + 33'd16;
            if (sz > 33'(ff)) begin
              st = dsa_pkg::StNoSpace;
            end else begin
              free_d = ff - FreeW'(sz); left_d = fl + sz[31:0]; res = fl + 32'd16;
              gnl = gran(left_d, base_q); gol = gran(fl, base_q);
              if (gnl[32]) begin
                lwe = gol[32]; lwa = LinkW'(gol[31:4]); lwd = LinkW'(gnl[31:4]);
                lwe2 = 1'b1; lwa2 = LinkW'(gnl[31:4]);
              end
            end
          end
        end
      end
      dsa_pkg::CmdAlloc, dsa_pkg::CmdPush: begin
        if (cmd_q == dsa_pkg::CmdPush && 32'(cnt_q) >= 32'(StateDepth)) begin
          st = dsa_pkg::StFull;
        end else begin
          if (cmd_q == dsa_pkg::CmdPush) begin
            sz = RecSize;
          end else begin
            sz = {1'b0, req_q} + 33'd15; sz = {sz[32:4], 4'd0} + 33'd16;
          end
          if (sz > 33'(free_q)) begin
            st = dsa_pkg::StNoSpace;
          end else begin
            free_d = free_q - FreeW'(sz);
            if (cmd_q == dsa_pkg::CmdAlloc && side_q) begin
              right_d = right_q - sz[31:0]; res = right_d + 32'd16;
              gnl = gran(right_d, base_q); gol = gran(right_q, base_q);
              lwe = gnl[32]; lwa = LinkW'(gnl[31:4]);
              lwd = gol[32] ? LinkW'(gol[31:4]) : '0;
            end else begin
              left_d = left_q + sz[31:0];
              res = (cmd_q == dsa_pkg::CmdPush) ? '0 : left_q + 32'd16;
              gnl = gran(left_d, base_q); gol = gran(left_q, base_q);
              if (gnl[32]) begin
                lwe = gol[32]; lwa = LinkW'(gol[31:4]); lwd = LinkW'(gnl[31:4]);
                lwe2 = 1'b1; lwa2 = LinkW'(gnl[31:4]);
              end
            end
            if (cmd_q == dsa_pkg::CmdPush) begin
              swe = 1'b1; cnt_d = cnt_q + SdW'(1);
            end
          end
        end
      end
      dsa_pkg::CmdPop: begin
        if (cnt_q == '0) begin
          st = dsa_pkg::StEmpty;
        end else begin
          cnt_d = cnt_q - SdW'(1);
          {free_d, left_d, right_d} = srd;
        end
      end
      default: begin
      end
    endcase
  end

  // Shared write port: a pending link clear to zero in the following cycle
  logic             lwe_m;
  logic [LinkW-1:0] lwa_m, lwd_m;
  always_comb begin
    lwe_m = busy_q && lwe; lwa_m = lwa; lwd_m = lwd;
    if (pend_q) begin
      lwe_m = 1'b1; lwa_m = pend_a_q; lwd_m = '0;
    end
  end

  // Sequence: accept, evaluate, drain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0; end_q <= 32'd65568;
      free_q <= '0; left_q <= '0; right_q <= '0; base_q <= '0; cnt_q <= '0;
      busy_q <= 1'b0; ovld_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == dsa_pkg::CfgStart) start_q <= cfg_wdata_i;
        else end_q <= cfg_wdata_i;
      end
      pend_q <= busy_q && lwe2;
      if (busy_q) begin
        busy_q <= 1'b0; ovld_q <= 1'b1;
        free_q <= free_d; left_q <= left_d; right_q <= right_d;
        base_q <= base_d; cnt_q <= cnt_d;
      end else begin
        if (m_axis_tready) ovld_q <= 1'b0;
        if (s_axis_tvalid && s_axis_tready) busy_q <= 1'b1;
      end
    end
  end

  // Capture request and result payloads
  logic [FreeW-1:0] la;
  assign la = (free_d > FreeW'(16)) ? free_d - FreeW'(16) : '0;
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tdata[2:0]; req_q <= s_axis_tdata[34:3];
      side_q <= s_axis_tdata[35]; baddr_q <= s_axis_tdata[67:36];
    end
    if (busy_q) begin
      odata_q <= {3'b0, 17'(la), 17'(free_d), st, res};
      pend_a_q <= lwa2;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;

  assign lwe_r = lwe_m;
  assign lwa_r = lwa_m;
  assign lwd_r = lwd_m;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q && m_axis_tvalid) else $error("result not produced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready) else $error("accept during evaluation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(StateDepth)) else $error("saved count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_q) <= 32'(MaxBytes)) else $error("free space over pool size");
endmodule
`default_nettype wire

FILE: hw/rtl/dsa_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none
module dsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: dv/double_ended_stack_allocator_unit_tb.sv
// Testbench for double_ended_stack_allocator_unit: runs allocator command streams
// under random source and sink stalls and checks every result against a local model.
// Depends on dsa_pkg and the unit itself.
`timescale 1ns / 100ps
`default_nettype none
module double_ended_stack_allocator_unit_tb;

  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  localparam int unsigned LinkDepth = dsa_pkg::PoolGranules + 2;
  localparam longint unsigned PoolMaxBytes = longint'(dsa_pkg::PoolGranules) * 16;

  typedef struct packed {
    logic [31:0] block_addr;
    logic        side;
    logic [31:0] req_size;
    logic [2:0]  cmd;
  } alloc_req_t;

  typedef struct packed {
    logic [16:0] largest;
    logic [16:0] free_bytes;
    logic [2:0]  status;
    logic [31:0] addr;
  } alloc_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  double_ended_stack_allocator_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Allocator model state
  logic [31:0] cfg_start = 32'd0;
  logic [31:0] cfg_end = 32'd65568;
  logic [31:0] free_sp = '0;
  logic [31:0] left_hd = '0;
  logic [31:0] right_hd = '0;
  logic [31:0] base_addr = '0;
  logic [31:0] link_mem [LinkDepth];
  bit          link_valid [LinkDepth];
  logic [31:0] snap_free [dsa_pkg::StateDepth];
  logic [31:0] snap_left [dsa_pkg::StateDepth];
  logic [31:0] snap_right [dsa_pkg::StateDepth];
  int unsigned snap_cnt = 0;

  alloc_req_t pend_q[$];
  alloc_rsp_t rsp_q[$];
  logic [31:0] addr_pool[$];
  logic [31:0] newest_left = '0;
  int unsigned mismatches = 0;
  bit no_idle = 1'b0;

  function automatic bit to_granule(input logic [31:0] a, output logic [31:0] g);
    logic [31:0] off;
    off = a - (base_addr - 32'd16);
    g = off >> 4;
    return (off[3:0] == 4'd0) && (g <= dsa_pkg::PoolGranules + 1);
  endfunction

  function automatic void link_write(input logic [31:0] g, input logic [31:0] v);
    if (g < LinkDepth) begin
      link_mem[g] = v;
      link_valid[g] = 1'b1;
    end
  endfunction

  function automatic logic [31:0] link_read(input logic [31:0] g);
    return (g < LinkDepth) ? link_mem[g] : 32'd0;
  endfunction

  function automatic void grow_free(input longint unsigned amount);
    longint unsigned f;
    f = longint'(free_sp) + amount;
    free_sp = (f > PoolMaxBytes) ? PoolMaxBytes[31:0] : f[31:0];
  endfunction

  function automatic bit model_alloc(input logic [31:0] req, input logic right,
                                     output logic [31:0] addr);
    longint unsigned sz;
    logic [31:0] prev, go, gn;
    sz = ((longint'(req) + 15) & ~64'd15) + 16;
    addr = '0;
    if (sz > free_sp) return 1'b0;
    free_sp = free_sp - sz[31:0];
    if (!right) begin
      prev = left_hd;
      left_hd = prev + sz[31:0];
      if (to_granule(left_hd, gn)) begin
        if (to_granule(prev, go)) link_write(go, gn);
        link_write(gn, 32'd0);
      end
      addr = prev + 32'd16;
    end else begin
      prev = right_hd;
      right_hd = prev - sz[31:0];
      if (to_granule(right_hd, gn)) link_write(gn, to_granule(prev, go) ? go : 32'd0);
      addr = right_hd + 32'd16;
    end
    return 1'b1;
  endfunction

  function automatic void model_free(input logic [31:0] addr);
    logic [31:0] hdr, hg, offh, offl, offr, n, org;
    org = base_addr - 32'd16;
    hdr = addr - 32'd16;
    if (!to_granule(hdr, hg)) return;
    offh = hg << 4;
    offl = left_hd - org;
    if (offh < offl) begin
      grow_free(longint'(offl - offh));
      left_hd = hdr;
      link_write(hg, 32'd0);
      return;
    end
    offr = right_hd - org;
    n = link_read(hg);
    if (offh >= offr && n > hg) begin
      grow_free(longint'(n) * 16 - longint'(offr));
      right_hd = org + (n << 4);
    end
  endfunction

  // Work out the response of one request and advance the model
  function automatic alloc_rsp_t predict_alloc(input alloc_req_t rq);
    alloc_rsp_t rs;
    longint ps, pe;
    logic [31:0] hg, lg, rec, fsv, lsv, rsv;
    rs = '0;
    case (rq.cmd)
      dsa_pkg::CmdInit: begin
        ps = longint'(((longint'(cfg_start) + 15) & ~64'd15) + 16);
        pe = longint'({cfg_end[31:4], 4'd0}) - 16;
        if (pe < ps || (pe - ps) > longint'(PoolMaxBytes)) begin
          rs.status = dsa_pkg::StBadInit;
        end else begin
          base_addr = ps[31:0];
          left_hd = base_addr - 32'd16;
          right_hd = pe[31:0];
          free_sp = pe[31:0] - ps[31:0];
          link_write(32'd0, 32'd0);
          link_write((free_sp >> 4) + 32'd1, 32'd0);
          snap_cnt = 0;
        end
      end
      dsa_pkg::CmdAlloc: begin
        if (!model_alloc(rq.req_size, rq.side, rs.addr)) rs.status = dsa_pkg::StNoSpace;
      end
      dsa_pkg::CmdFree: model_free(rq.block_addr);
      dsa_pkg::CmdRealloc: begin
        if (to_granule(rq.block_addr - 32'd16, hg) && to_granule(left_hd, lg) &&
            hg < lg && link_read(hg) == lg) begin
          model_free(rq.block_addr);
          if (!model_alloc(rq.req_size, 1'b0, rs.addr)) rs.status = dsa_pkg::StNoSpace;
        end else begin
          rs.status = dsa_pkg::StNotNewest;
        end
      end
      dsa_pkg::CmdPush: begin
        if (snap_cnt >= dsa_pkg::StateDepth) begin
          rs.status = dsa_pkg::StFull;
        end else begin
          fsv = free_sp;
          lsv = left_hd;
          rsv = right_hd;
          if (model_alloc(dsa_pkg::StateRecordBytes, 1'b0, rec)) begin
            snap_free[snap_cnt] = fsv;
            snap_left[snap_cnt] = lsv;
            snap_right[snap_cnt] = rsv;
            snap_cnt++;
          end else begin
            rs.status = dsa_pkg::StNoSpace;
          end
          rs.addr = '0;
        end
      end
      dsa_pkg::CmdPop: begin
        if (snap_cnt == 0) begin
          rs.status = dsa_pkg::StEmpty;
        end else begin
          snap_cnt--;
          free_sp = snap_free[snap_cnt];
          left_hd = snap_left[snap_cnt];
          right_hd = snap_right[snap_cnt];
        end
      end
      default: ;
    endcase
    rs.free_bytes = free_sp[16:0];
    rs.largest = (free_sp > 32'd16) ? free_sp[16:0] - 17'd16 : 17'd0;
    return rs;
  endfunction

  // Queue one request; steer addresses away from link entries never written
  task automatic send_req(input logic [2:0] cmd, input logic [31:0] req,
                          input logic side, input logic [31:0] baddr);
    alloc_req_t rq;
    alloc_rsp_t rs;
    logic [31:0] hg;
    if ((cmd == dsa_pkg::CmdFree || cmd == dsa_pkg::CmdRealloc) &&
        to_granule(baddr - 32'd16, hg) && !link_valid[hg]) begin
      baddr = baddr ^ 32'd4;
    end
    rq = '{block_addr: baddr, side: side, req_size: req, cmd: cmd};
    rs = predict_alloc(rq);
    if (cmd == dsa_pkg::CmdAlloc && rs.status == dsa_pkg::StOk) begin
      if (addr_pool.size() >= 64) void'(addr_pool.pop_front());
      addr_pool.push_back(rs.addr);
      if (!side) newest_left = rs.addr;
    end
    if (cmd == dsa_pkg::CmdRealloc && rs.status == dsa_pkg::StOk) newest_left = rs.addr;
    pend_q.push_back(rq);
    rsp_q.push_back(rs);
  endtask

  function automatic logic [31:0] pick_addr();
    if (addr_pool.size() > 0 && $urandom_range(0, 9) < 8)
      return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic send_random();
    int unsigned r;
    logic [31:0] req;
    r = $urandom_range(0, 99);
    req = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 400);
    if (r < 40) send_req(dsa_pkg::CmdAlloc, req, 1'($urandom_range(0, 1)), $urandom());
    else if (r < 58)
      send_req(dsa_pkg::CmdFree, $urandom(), 1'($urandom_range(0, 1)), pick_addr());
    else if (r < 70)
      send_req(dsa_pkg::CmdRealloc, req, 1'($urandom_range(0, 1)),
               $urandom_range(0, 1) ? newest_left : pick_addr());
    else if (r < 80)
      send_req(dsa_pkg::CmdPush, $urandom(), 1'($urandom_range(0, 1)), $urandom());
    else if (r < 89)
      send_req(dsa_pkg::CmdPop, $urandom(), 1'($urandom_range(0, 1)), $urandom());
    else if (r < 92)
      send_req(dsa_pkg::CmdInit, $urandom(), 1'($urandom_range(0, 1)), $urandom());
    else if (r < 96)
      send_req($urandom_range(0, 1) ? CmdSpare6 : CmdSpare7, $urandom(),
               1'($urandom_range(0, 1)), $urandom());
    else send_req(dsa_pkg::CmdAlloc, $urandom(), 1'($urandom_range(0, 1)), $urandom());
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == dsa_pkg::CfgStart) cfg_start = val;
    else cfg_end = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every request is accepted and every response has come back
  task automatic drain();
    while (pend_q.size() != 0 || s_axis_tvalid || rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Source side: present queued requests with random gaps
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          s_axis_tdata <= {4'd0, pend_q.pop_front()};
          s_axis_tvalid <= 1'b1;
          send_gap <= no_idle ? 0 : $urandom_range(0, 9);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink side: random stalls, compare each response with the oldest prediction
  int unsigned sink_wait = 0;
  always @(posedge clk_i) begin
    alloc_rsp_t got, want;
    int unsigned w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[68:0];
        if (rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", got);
        end else begin
          want = rsp_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: addr %h/%h status %0d/%0d free %0d/%0d largest %0d/%0d",
                       want.addr, got.addr, want.status, got.status,
                       want.free_bytes, got.free_bytes, want.largest, got.largest);
          end
        end
        w = no_idle ? 0 : $urandom_range(0, 9);
        sink_wait <= w;
        m_axis_tready <= (w == 0);
      end else if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] starts [6];
    logic [31:0] ends [6];
    starts = '{32'd0, 32'h0000_1000, 32'hFFFE_FFE0, 32'd3, 32'hFFFF_FFFF, 32'h0000_2000};
    ends = '{32'd65568, 32'h0000_1400, 32'hFFFF_FFFF, 32'h0002_0000, 32'hFFFF_FFFF,
             32'h0000_2100};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed corners on the reset configuration
    send_req(dsa_pkg::CmdAlloc, 32'd8, 1'b0, 32'd0);
    send_req(dsa_pkg::CmdPop, 32'd0, 1'b0, 32'd0);
    send_req(dsa_pkg::CmdInit, 32'd0, 1'b0, 32'd0);
    send_req(dsa_pkg::CmdAlloc, 32'd0, 1'b0, 32'd0);
    send_req(dsa_pkg::CmdAlloc, 32'd17, 1'b1, 32'd0);
    send_req(dsa_pkg::CmdAlloc, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    send_req(dsa_pkg::CmdAlloc, 32'd100, 1'b0, 32'd0);
    send_req(dsa_pkg::CmdRealloc, 32'd300, 1'b0, newest_left);
    send_req(dsa_pkg::CmdRealloc, 32'd16, 1'b0, 32'd48);
    send_req(dsa_pkg::CmdRealloc, 32'd70000, 1'b0, newest_left);
    send_req(dsa_pkg::CmdAlloc, 32'd64, 1'b1, 32'd0);
    send_req(dsa_pkg::CmdFree, 32'd0, 1'b1, addr_pool[1]);
    send_req(dsa_pkg::CmdFree, 32'd0, 1'b0, 32'h1234_5677);
    send_req(dsa_pkg::CmdFree, 32'd0, 1'b0, addr_pool[0]);
    repeat (17) send_req(dsa_pkg::CmdPush, 32'd0, 1'b0, 32'd0);
    send_req(dsa_pkg::CmdPop, 32'd0, 1'b0, 32'd0);
    send_req(CmdSpare6, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_req(CmdSpare7, 32'd0, 1'b0, 32'd0);
    send_req(dsa_pkg::CmdAlloc, 32'd65520, 1'b1, 32'd0);
    drain();

    // Random phases, one pool layout each; the sender waits for all responses between
    for (int p = 0; p < 6; p++) begin
      write_cfg(dsa_pkg::CfgStart, starts[p]);
      write_cfg(dsa_pkg::CfgEnd, ends[p]);
      no_idle = (p == 3);
      send_req(dsa_pkg::CmdInit, 32'd0, 1'b0, 32'd0);
      for (int i = 0; i < 122; i++) send_random();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && rsp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
hw/rtl/dsa_pkg.sv
hw/rtl/dsa_ram.sv
hw/rtl/double_ended_stack_allocator_unit.sv
dv/double_ended_stack_allocator_unit_tb.sv
